>>> rtl/bpc_pkg.sv
package bpc_pkg;

    localparam int DivW = 32;
    localparam int DivStages = 32;

    localparam logic [1:0] REG_OSS   = 2'd0;
    localparam logic [1:0] REG_CAL_A = 2'd1;
    localparam logic [1:0] REG_CAL_B = 2'd2;
    localparam logic [1:0] REG_CAL_C = 2'd3;

    localparam logic [31:0] C_B6_OFS   = 32'd4000;
    localparam logic [31:0] C_P_SQ     = 32'd3038;
    localparam logic [31:0] C_P_LIN    = 32'hFFFF_E343; // -7357
    localparam logic [31:0] C_P_OFS    = 32'd3791;
    localparam logic [31:0] C_B7_SCALE = 32'd50000;
    localparam logic [31:0] C_MMHG_DIV = 32'd133322;
    localparam logic [31:0] C_B4_OFS   = 32'd32768;
    localparam logic [31:0] C_MMHG_MUL = 32'd1000;

    // Rounded-up reciprocal of half the mmHg divisor, scaled by 2^48.
    localparam logic [31:0] C_MMHG_RECIP =
        32'(((64'd1 << 48) / 64'(C_MMHG_DIV >> 1)) + 64'd1);

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
        logic [1:0]  oss;
    } cal_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

>>> rtl/bpc_udiv.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
// A side-band word travels along with each operand pair.
module bpc_udiv #(
    parameter int SideW = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [bpc_pkg::DivW-1:0]   in_num,
    input  logic [bpc_pkg::DivW-1:0]   in_den,
    input  logic [SideW-1:0]           in_side,
    output logic                       out_valid,
    output logic [bpc_pkg::DivW-1:0]   out_quo,
    output logic [SideW-1:0]           out_side
);
    localparam int W = bpc_pkg::DivW;
    localparam int N = bpc_pkg::DivStages;

    logic [N:1]       vld_reg;
    logic [W-1:0]     rem_reg  [N+1];
    logic [W-1:0]     num_reg  [N+1];
    logic [W-1:0]     den_reg  [N+1];
    logic [SideW-1:0] side_reg [N+1];

    assign rem_reg[0]  = '0;
    assign num_reg[0]  = in_num;
    assign den_reg[0]  = in_den;
    assign side_reg[0] = in_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-1:1], in_valid};
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [W:0]   trial;
        logic [W:0]   diff;
        always_comb
        begin
            trial = {rem_reg[s], num_reg[s][W-1]};
            diff  = trial - {1'b0, den_reg[s]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!diff[W])
                begin
                    rem_reg[s+1] <= diff[W-1:0];
                end
                else
                begin
                    rem_reg[s+1] <= trial[W-1:0];
                end
                num_reg[s+1]  <= {num_reg[s][W-2:0], ~diff[W]};
                den_reg[s+1]  <= den_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign out_quo   = num_reg[N];
    assign out_side  = side_reg[N];

endmodule

>>> rtl/bpc_temp.sv
// Temperature front end: x1, the numerator and divisor for x2, and up.
module bpc_temp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  bpc_pkg::cal_t      cal,
    input  logic               in_valid,
    input  logic [15:0]        raw_temperature,
    input  logic [23:0]        raw_pressure,
    output logic               out_valid,
    output logic [31:0]        x1,
    output logic [31:0]        num_abs,
    output logic [31:0]        den_abs,
    output logic               q_neg,
    output logic               den_zero,
    output logic [31:0]        up
);
    logic        v1_reg, v2_reg;
    logic [31:0] diff_reg, up1_reg;
    logic [31:0] x1_reg, up2_reg, num_reg, den_reg;
    logic [31:0] prod;
    logic [31:0] x1_next, num_next, den_next;

    always_comb
    begin
        prod     = diff_reg * {16'd0, cal.ac5};
        x1_next  = 32'($signed(prod) >>> 15);
        num_next = bpc_pkg::sx16(cal.mc) << 11;
        den_next = x1_next + bpc_pkg::sx16(cal.md);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= {16'd0, raw_temperature} - {16'd0, cal.ac6};
            up1_reg  <= {8'd0, raw_pressure} >> (4'd8 - {2'd0, cal.oss});
            x1_reg   <= x1_next;
            num_reg  <= num_next;
            den_reg  <= den_next;
            up2_reg  <= up1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign x1        = x1_reg;
    assign num_abs   = num_reg[31] ? (32'd0 - num_reg) : num_reg;
    assign den_abs   = den_reg[31] ? (32'd0 - den_reg) : den_reg;
    assign q_neg     = num_reg[31] ^ den_reg[31];
    assign den_zero  = (den_reg == 32'd0);
    assign up        = up2_reg;

endmodule

>>> rtl/bpc_press.sv
// Pressure terms from b5: b3, b4 and b7, over registered stages.
module bpc_press (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  bpc_pkg::cal_t      cal,
    input  logic               in_valid,
    input  logic [31:0]        b5,
    input  logic [31:0]        up,
    output logic               out_valid,
    output logic [31:0]        b4,
    output logic [31:0]        b7
);
    logic [4:0]  v_reg;
    logic [31:0] b6_reg, up1_reg, sq_reg, b6b_reg, up2_reg;
    logic [31:0] t1_reg, t2_reg, t3_reg, t4_reg, up3_reg;
    logic [31:0] b3_reg, x3_reg, up4_reg;
    logic [31:0] b4_reg, b7_reg;
    logic [31:0] sqp, p1, p2, p3, p4, xs, b3_next, x3_next, b4p;

    always_comb
    begin
        sqp     = b6_reg * b6_reg;
        p1      = bpc_pkg::sx16(cal.b2) * sq_reg;
        p2      = bpc_pkg::sx16(cal.ac2) * b6b_reg;
        p3      = bpc_pkg::sx16(cal.ac3) * b6b_reg;
        p4      = bpc_pkg::sx16(cal.b1) * sq_reg;
        xs      = (bpc_pkg::sx16(cal.ac1) << 2) + t1_reg + t2_reg;
        b3_next = 32'($signed((xs << cal.oss) + 32'd2) >>> 2);
        x3_next = 32'($signed(t3_reg + t4_reg + 32'd2) >>> 2);
        b4p     = {16'd0, cal.ac4} * (x3_reg + bpc_pkg::C_B4_OFS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b6_reg  <= b5 - bpc_pkg::C_B6_OFS;
            up1_reg <= up;
            sq_reg  <= 32'($signed(sqp) >>> 12);
            b6b_reg <= b6_reg;
            up2_reg <= up1_reg;
            t1_reg  <= 32'($signed(p1) >>> 11);
            t2_reg  <= 32'($signed(p2) >>> 11);
            t3_reg  <= 32'($signed(p3) >>> 13);
            t4_reg  <= 32'($signed(p4) >>> 16);
            up3_reg <= up2_reg;
            b3_reg  <= b3_next;
            x3_reg  <= x3_next;
            up4_reg <= up3_reg;
            b4_reg  <= b4p >> 15;
            b7_reg  <= (up4_reg - b3_reg) * (bpc_pkg::C_B7_SCALE >> cal.oss);
        end
    end

    assign out_valid = v_reg[4];
    assign b4        = b4_reg;
    assign b7        = b7_reg;

endmodule

>>> rtl/barometric_pressure_compensation_core.sv
// The datapath is 79 register stages deep from an accepted beat to out_valid.
// Throughput: one beat per cycle; a single stall signal freezes every stage.
// Two 32-stage pipelined dividers (x2, p) set most of the latency.
// Reset (rst_n, asynchronous, active low) clears all valid bits and
// returns every configuration register to zero.
module barometric_pressure_compensation_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] raw_temperature,
    input  logic [23:0] raw_pressure,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] temperature_tenths,
    output logic [31:0] pressure_pascal,
    output logic [31:0] pressure_mmhg,
    output logic        divide_fault
);
    // Configuration registers. The user must issue writes only while idle; the block does not enforce this.
    logic [1:0]  oss_reg;
    logic [63:0] cal_a_reg, cal_b_reg;
    logic [31:0] cal_c_reg;
    bpc_pkg::cal_t cal;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oss_reg   <= '0;
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bpc_pkg::REG_OSS:   oss_reg   <= cfg_data[1:0];
                bpc_pkg::REG_CAL_A: cal_a_reg <= cfg_data;
                bpc_pkg::REG_CAL_B: cal_b_reg <= cfg_data;
                bpc_pkg::REG_CAL_C: cal_c_reg <= cfg_data[31:0];
                default:            oss_reg   <= oss_reg;
            endcase
        end
    end

    always_comb
    begin
        cal.ac1 = cal_a_reg[15:0];
        cal.ac2 = cal_a_reg[31:16];
        cal.ac3 = cal_a_reg[47:32];
        cal.ac4 = cal_a_reg[63:48];
        cal.ac5 = cal_b_reg[15:0];
        cal.ac6 = cal_b_reg[31:16];
        cal.b1  = cal_b_reg[47:32];
        cal.b2  = cal_b_reg[63:48];
        cal.mc  = cal_c_reg[15:0];
        cal.md  = cal_c_reg[31:16];
        cal.oss = oss_reg;
    end

    // The whole pipeline advances together. The output register is the
    // last stage; the pipe moves whenever that register is empty or drained.
    logic en;
    logic out_vld_reg;
    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    // Temperature front end.
    logic        t_vld, t_neg, t_dz;
    logic [31:0] t_x1, t_num, t_den, t_up;

    bpc_temp u_temp (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .cal             (cal),
        .in_valid        (in_valid),
        .raw_temperature (raw_temperature),
        .raw_pressure    (raw_pressure),
        .out_valid       (t_vld),
        .x1              (t_x1),
        .num_abs         (t_num),
        .den_abs         (t_den),
        .q_neg           (t_neg),
        .den_zero        (t_dz),
        .up              (t_up)
    );

    // x2 divider; side-band carries x1, up, the quotient sign and the fault.
    localparam int S1W = 66;
    logic           d1_vld;
    logic [31:0]    d1_quo;
    logic [S1W-1:0] d1_side;

    bpc_udiv #(.SideW(S1W)) u_div_x2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t_vld),
        .in_num    (t_num),
        .in_den    (t_den),
        .in_side   ({t_x1, t_up, t_neg, t_dz}),
        .out_valid (d1_vld),
        .out_quo   (d1_quo),
        .out_side  (d1_side)
    );

    // Join x1 and x2 into b5 and derive the temperature.
    logic        b5_vld_reg, f1_reg;
    logic [31:0] b5_reg, temp_reg, up5_reg;
    logic [31:0] x2, b5_next;

    always_comb
    begin
        if (d1_side[0])
        begin
            x2 = '0;
        end
        else if (d1_side[1])
        begin
            x2 = 32'd0 - d1_quo;
        end
        else
        begin
            x2 = d1_quo;
        end
        b5_next = d1_side[65:34] + x2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b5_vld_reg <= d1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b5_reg   <= b5_next;
            temp_reg <= 32'($signed(b5_next + 32'd8) >>> 4);
            up5_reg  <= d1_side[33:2];
            f1_reg   <= d1_side[0];
        end
    end

    // Pressure terms. Temperature and fault ride alongside in a short delay line.
    logic        p_vld;
    logic [31:0] p_b4, p_b7;
    logic [31:0] td_reg [5];
    logic [4:0]  fd_reg;

    bpc_press u_press (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cal       (cal),
        .in_valid  (b5_vld_reg),
        .b5        (b5_reg),
        .up        (up5_reg),
        .out_valid (p_vld),
        .b4        (p_b4),
        .b7        (p_b7)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            td_reg[0] <= temp_reg;
            for (int i = 1; i < 5; i++)
            begin
                td_reg[i] <= td_reg[i-1];
            end
            fd_reg <= {fd_reg[3:0], f1_reg};
        end
    end

    // p divider: when b7 has its top bit set, divide b7 and double afterward.
    localparam int S2W = 35;
    logic           d2_vld;
    logic [31:0]    d2_quo;
    logic [S2W-1:0] d2_side;
    logic           b4_zero, late;

    assign b4_zero = (p_b4 == 32'd0);
    assign late    = p_b7[31];

    bpc_udiv #(.SideW(S2W)) u_div_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_vld),
        .in_num    (late ? p_b7 : (p_b7 << 1)),
        .in_den    (p_b4),
        .in_side   ({td_reg[4], late, b4_zero, fd_reg[4]}),
        .out_valid (d2_vld),
        .out_quo   (d2_quo),
        .out_side  (d2_side)
    );

    // Final correction: pa = p + ((x1 + x2 + 3791) >> 4), over four stages.
    // p is delayed alongside so that it meets its own correction terms.
    logic [3:0]  c_vld_reg;
    logic [31:0] p_reg, ps_reg, p2_reg, p3_reg, x1a_reg, x2a_reg, pa_reg;
    logic [31:0] tc_reg [4];
    logic [3:0]  fc_reg;
    logic [31:0] p_val, pss, x1m, x2m, corr;

    always_comb
    begin
        if (d2_side[1])
        begin
            p_val = '0;
        end
        else if (d2_side[2])
        begin
            p_val = d2_quo << 1;
        end
        else
        begin
            p_val = d2_quo;
        end
        pss  = 32'($signed(p_reg) >>> 8);
        x1m  = ps_reg * bpc_pkg::C_P_SQ;
        x2m  = bpc_pkg::C_P_LIN * p2_reg;
        corr = 32'($signed(x1a_reg + x2a_reg + bpc_pkg::C_P_OFS) >>> 4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= '0;
        end
        else if (en)
        begin
            c_vld_reg <= {c_vld_reg[2:0], d2_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= p_val;
            ps_reg    <= pss * pss;
            p2_reg    <= p_reg;
            x1a_reg   <= 32'($signed(x1m) >>> 16);
            x2a_reg   <= 32'($signed(x2m) >>> 16);
            p3_reg    <= p2_reg;
            pa_reg    <= p3_reg + corr;
            tc_reg[0] <= d2_side[34:3];
            tc_reg[1] <= tc_reg[0];
            tc_reg[2] <= tc_reg[1];
            tc_reg[3] <= tc_reg[2];
            fc_reg    <= {fc_reg[2:0], d2_side[0] | d2_side[1]};
        end
    end

    // mmHg: |pa * 1000| / 133322 by reciprocal multiplication. Halving the
    // magnitude first leaves a divisor of 66661; its rounded-up reciprocal
    // scaled by 2^48 gives the exact quotient for every halved magnitude up
    // to 2^30. The magnitude is formed in one stage, the product in the next,
    // and the sign is put back in the output register.
    logic [1:0]  m_vld_reg;
    logic [31:0] mm_num, mag_reg, mm_q;
    logic [63:0] mprod_reg;
    logic [31:0] mt_reg [2];
    logic [31:0] mp_reg [2];
    logic [1:0]  mn_reg, mf_reg;

    assign mm_num = pa_reg * bpc_pkg::C_MMHG_MUL;
    assign mm_q   = {16'd0, mprod_reg[63:48]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= '0;
        end
        else if (en)
        begin
            m_vld_reg <= {m_vld_reg[0], c_vld_reg[3]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mm_num[31] ? (32'd0 - mm_num) : mm_num;
            mprod_reg <= {33'd0, mag_reg[31:1]} * {32'd0, bpc_pkg::C_MMHG_RECIP};
            mt_reg[0] <= tc_reg[3];
            mt_reg[1] <= mt_reg[0];
            mp_reg[0] <= pa_reg;
            mp_reg[1] <= mp_reg[0];
            mn_reg    <= {mn_reg[0], mm_num[31]};
            mf_reg    <= {mf_reg[0], fc_reg[3]};
        end
    end

    // Output register.
    logic [31:0] temp_out_reg, pa_out_reg, mm_out_reg;
    logic        fault_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= m_vld_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp_out_reg  <= mt_reg[1];
            pa_out_reg    <= mp_reg[1];
            mm_out_reg    <= mn_reg[1] ? (32'd0 - mm_q) : mm_q;
            fault_out_reg <= mf_reg[1];
        end
    end

    assign out_valid          = out_vld_reg;
    assign temperature_tenths = temp_out_reg;
    assign pressure_pascal    = pa_out_reg;
    assign pressure_mmhg      = mm_out_reg;
    assign divide_fault       = fault_out_reg;

endmodule
